// File: hw/rtl/srfp_pkg.sv
package srfp_pkg;

  // Largest number of data bytes taken from one reply.
  localparam int unsigned MaxData = 16;
  // Width of the data byte counters; they must hold MaxData itself.
  localparam int unsigned CntW = $clog2(MaxData + 1);

  // Field widths of the result beat.
  localparam int unsigned IndexW = 4;
  localparam int unsigned CountW = 5;

  // Frame constants.
  localparam logic [7:0] HeaderByte  = 8'hFF;
  localparam logic [7:0] LenOverhead = 8'd2;

  // Input operation codes.
  typedef enum logic {
    OpArm  = 1'b0,
    OpByte = 1'b1
  } op_e;

  // Result kinds.
  typedef enum logic {
    KindData = 1'b0,
    KindDone = 1'b1
  } kind_e;

  // One result beat.
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data_value;
    logic [IndexW-1:0]  data_index;
    logic [7:0]         frame_id;
    logic [7:0]         servo_status;
    logic               checksum_ok;
    logic [CountW-1:0]  data_count;
  } result_t;

endpackage

// File: hw/rtl/servo_reply_frame_parser_unit.sv
// An accepted input beat waits in the input register, and its result beat, if any, is
// offered from the result register. Throughput: one input beat per cycle unless a stalled
// result holds a beat that gives one; the input and result registers each hold one beat.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser
// to waiting for the first header with no echo bytes pending.
module servo_reply_frame_parser_unit
  import srfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [7:0]        byte_value_i,
  input  logic [7:0]        echo_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic [7:0]        data_value_o,
  output logic [IndexW-1:0] data_index_o,
  output logic [7:0]        frame_id_o,
  output logic [7:0]        servo_status_o,
  output logic              checksum_ok_o,
  output logic [CountW-1:0] data_count_o
);

  logic       in_vld_q, in_vld_d;
  logic       op_q;
  logic [7:0] byte_q;
  logic [7:0] echo_q;
  logic       in_fire;
  logic       advance;
  logic       res_valid;
  logic       out_space;
  result_t    res;
  result_t    out_res;

  // A held beat moves on unless it yields a result and the output is full.
  assign advance    = in_vld_q && (!res_valid || out_space);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= operation_i;
      byte_q <= byte_value_i;
      echo_q <= echo_length_i;
    end
  end

  srfp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .operation_i   (op_q),
    .byte_value_i  (byte_q),
    .echo_length_i (echo_q),
    .res_valid_o   (res_valid),
    .result_o      (res)
  );

  srfp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && res_valid),
    .result_i (res),
    .space_o  (out_space),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_res)
  );

  // Result fields onto their own ports.
  assign kind_o         = out_res.kind;
  assign data_value_o   = out_res.data_value;
  assign data_index_o   = out_res.data_index;
  assign frame_id_o     = out_res.frame_id;
  assign servo_status_o = out_res.servo_status;
  assign checksum_ok_o  = out_res.checksum_ok;
  assign data_count_o   = out_res.data_count;

endmodule

// File: hw/rtl/srfp_parser.sv
module srfp_parser
  import srfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       operation_i,
  input  logic [7:0] byte_value_i,
  input  logic [7:0] echo_length_i,
  output logic       res_valid_o,
  output result_t    result_o
);

  // One-hot parser phases.
  typedef enum logic [6:0] {
    PhH1   = 7'b0000001,
    PhH2   = 7'b0000010,
    PhId   = 7'b0000100,
    PhLen  = 7'b0001000,
    PhErr  = 7'b0010000,
    PhData = 7'b0100000,
    PhCsum = 7'b1000000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      echo_q, echo_d;
  logic [7:0]      id_q, id_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      status_q, status_d;
  logic [7:0]      sum_q, sum_d;
  logic [CntW-1:0] expected_q, expected_d;
  logic [CntW-1:0] received_q, received_d;

  logic [7:0]      data_len;
  logic [CntW-1:0] received_inc;

  // Data length from the LEN byte, floored at zero and clamped to the buffer.
  always_comb begin
    data_len = (len_q >= LenOverhead) ? (len_q - LenOverhead) : 8'd0;
    if (data_len > 8'(MaxData)) begin
      data_len = 8'(MaxData);
    end
  end

  assign received_inc = received_q + CntW'(1);

  // Next state and result for the beat being processed.
  always_comb begin
    phase_d     = phase_q;
    echo_d      = echo_q;
    id_d        = id_q;
    len_d       = len_q;
    status_d    = status_q;
    sum_d       = sum_q;
    expected_d  = expected_q;
    received_d  = received_q;
    res_valid_o = 1'b0;
    result_o    = '0;

    if (operation_i == OpArm) begin
      // Arm: load the echo count and restart the frame parser.
      echo_d     = echo_length_i;
      phase_d    = PhH1;
      expected_d = '0;
      received_d = '0;
    end else if (echo_q != 8'd0) begin
      // Our own transmitted bytes come back first; drop them.
      echo_d = echo_q - 8'd1;
    end else begin
      case (phase_q)
        PhH2: begin
          phase_d = (byte_value_i == HeaderByte) ? PhId : PhH1;
        end
        PhId: begin
          id_d    = byte_value_i;
          sum_d   = byte_value_i;
          phase_d = PhLen;
        end
        PhLen: begin
          len_d   = byte_value_i;
          sum_d   = sum_q + byte_value_i;
          phase_d = PhErr;
        end
        PhErr: begin
          status_d   = byte_value_i;
          sum_d      = sum_q + byte_value_i;
          received_d = '0;
          expected_d = CntW'(data_len);
          phase_d    = (data_len != 8'd0) ? PhData : PhCsum;
        end
        PhData: begin
          sum_d                = sum_q + byte_value_i;
          res_valid_o          = 1'b1;
          result_o.kind        = KindData;
          result_o.data_value  = byte_value_i;
          result_o.data_index  = IndexW'(received_q);
          received_d           = received_inc;
          if (received_inc >= expected_q) begin
            phase_d = PhCsum;
          end
        end
        PhCsum: begin
          res_valid_o           = 1'b1;
          result_o.kind         = KindDone;
          result_o.frame_id     = id_q;
          result_o.servo_status = status_q;
          result_o.checksum_ok  = (byte_value_i == ~sum_q);
          result_o.data_count   = CountW'(expected_q);
          phase_d               = PhH1;
        end
        default: begin
          // Waiting for the first header; unknown codes behave the same.
          phase_d = (byte_value_i == HeaderByte) ? PhH2 : PhH1;
        end
      endcase
    end
  end

  // Parser state advances only when a beat is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhH1;
      echo_q     <= '0;
      id_q       <= '0;
      len_q      <= '0;
      status_q   <= '0;
      sum_q      <= '0;
      expected_q <= '0;
      received_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      echo_q     <= echo_d;
      id_q       <= id_d;
      len_q      <= len_d;
      status_q   <= status_d;
      sum_q      <= sum_d;
      expected_q <= expected_d;
      received_q <= received_d;
    end
  end

  // An arm beat restarts the parser with the given echo count.
  a_arm_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && operation_i == OpArm) |=>
      (phase_q == PhH1 && echo_q == $past(echo_length_i)))
    else $error("arm beat did not restart the parser");

  // While taking data the count never reaches the expected length.
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (received_q < expected_q))
    else $error("data phase with all data already received");

  // No result comes out while echo bytes are still being dropped.
  a_no_result_in_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (echo_q == 8'd0 && operation_i == OpByte))
    else $error("result produced during echo or arm");

endmodule

// File: hw/rtl/srfp_out_reg.sv
module srfp_out_reg
  import srfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // The register can take a new beat when empty or being drained.
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
